/* sv/nfv5_pkg.sv */
// Shared constants, status codes and the front-to-back queue entry of the NetFlow v5 parser.
package nfv5_pkg;

    // Packet layout
    localparam int MAX_RECORDS  = 30;
    localparam int HEADER_BYTES = 24;
    localparam int RECORD_BYTES = 48;
    localparam logic [15:0] NF_VERSION = 16'd5;

    // Front position counters
    localparam int HPOS_W = $clog2(HEADER_BYTES + 1);
    localparam int OFF_W  = $clog2(RECORD_BYTES);
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Time arithmetic constants
    localparam logic [31:0] NS_PER_SEC    = 32'd1000000000;
    localparam logic [19:0] NS_PER_MS     = 20'd1000000;
    localparam logic [9:0]  MS_PER_SEC    = 10'd1000;
    // ceil(2^38 / 1000): exact quotient of any 32-bit value by 1000 after >> 38
    localparam logic [28:0] DIV1000_MAGIC = 29'd274877907;
    localparam int DIV1000_SHIFT = 38;
    localparam int PROD_W        = 32 + 29;
    localparam int DQ_W          = PROD_W - DIV1000_SHIFT;
    localparam int NSEC_Q_MAX    = 4;
    localparam int NR_W          = 30;
    localparam int BASE_W        = 35;

    typedef enum logic [2:0] {
        ST_RECORD      = 3'd0,
        ST_TRUNCATED   = 3'd1,
        ST_BAD_VERSION = 3'd2,
        ST_TOO_MANY    = 3'd3,
        ST_SHORT_DATA  = 3'd4
    } t_status;

    // One result as handed from the front to the back, with the header timebase
    typedef struct packed {
        t_status     status;
        logic        last_record;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [7:0]  protocol;
        logic [31:0] packet_count;
        logic [31:0] octet_count;
        logic [31:0] first_ms;
        logic [31:0] last_ms;
        logic [31:0] uptime;
        logic [31:0] seconds;
        logic [31:0] nanoseconds;
    } t_entry;

endpackage

/* sv/nfv5_if.sv */
// Valid/ready channel interfaces for packet bytes in and parsed results out.
interface nfv5_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] packet_length;
    logic        from_originator;

    modport source (output valid, data_byte, first_byte, packet_length, from_originator,
                    input ready);
    modport sink   (input valid, data_byte, first_byte, packet_length, from_originator,
                    output ready);
endinterface

interface nfv5_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] start_seconds;
    logic [31:0] end_seconds;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [7:0]  protocol;
    logic [31:0] packet_count;
    logic [31:0] octet_count;
    logic        last_record;

    modport source (output valid, status, start_seconds, end_seconds, source_address,
                    destination_address, source_port, destination_port, protocol,
                    packet_count, octet_count, last_record,
                    input ready);
    modport sink   (input valid, status, start_seconds, end_seconds, source_address,
                    destination_address, source_port, destination_port, protocol,
                    packet_count, octet_count, last_record,
                    output ready);
endinterface

/* sv/nfv5_front.sv */
// Byte-level parser: header checks, record field capture and result push into the queue.
module nfv5_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    nfv5_in_if.sink          i_in,
    input  logic             i_full,
    output logic             o_push,
    output nfv5_pkg::t_entry o_entry
);
    import nfv5_pkg::*;

    // Parser state
    logic [HPOS_W-1:0] r_hpos, n_hpos;
    logic [OFF_W-1:0]  r_off, n_off;
    logic [CNT_W-1:0]  r_recnum, n_recnum;
    logic [CNT_W-1:0]  r_total, n_total;
    logic              r_dropped, n_dropped;
    logic [7:0]        r_ver_hi, n_ver_hi;
    logic [7:0]        r_cnt_hi, n_cnt_hi;
    logic [31:0]       r_uptime, n_uptime;
    logic [31:0]       r_secs, n_secs;
    logic [31:0]       r_nsecs, n_nsecs;

    // Record fields, shifted in as their bytes go by
    logic [31:0] r_src, n_src;
    logic [31:0] r_dst, n_dst;
    logic [31:0] r_pkts, n_pkts;
    logic [31:0] r_octs, n_octs;
    logic [31:0] r_first, n_first;
    logic [31:0] r_last, n_last;
    logic [15:0] r_sport, n_sport;
    logic [15:0] r_dport, n_dport;
    logic [7:0]  r_proto, n_proto;

    logic              accept;
    logic              active;
    logic [7:0]        b;
    logic [HPOS_W-1:0] cur_pos;
    logic [OFF_W-1:0]  cur_off;
    logic [CNT_W-1:0]  cur_rec;
    logic [CNT_W:0]    rec_next;
    logic [15:0]       count;
    logic [15:0]       need_len;
    logic              err_fire;
    t_status           err_code;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;
    assign active     = accept && i_in.from_originator && (i_in.first_byte || !r_dropped);
    assign b          = i_in.data_byte;
    assign cur_pos    = i_in.first_byte ? '0 : r_hpos;
    assign cur_off    = i_in.first_byte ? '0 : r_off;
    assign cur_rec    = i_in.first_byte ? '0 : r_recnum;
    assign rec_next   = {1'b0, cur_rec} + (CNT_W + 1)'(1);
    assign count      = {r_cnt_hi, b};
    assign need_len   = 16'(HEADER_BYTES) + 16'(count[CNT_W-1:0]) * 16'(RECORD_BYTES);

    // Next-state logic for one beat
    always_comb begin
        n_hpos    = r_hpos;
        n_off     = r_off;
        n_recnum  = r_recnum;
        n_total   = r_total;
        n_dropped = r_dropped;
        n_ver_hi  = r_ver_hi;
        n_cnt_hi  = r_cnt_hi;
        n_uptime  = r_uptime;
        n_secs    = r_secs;
        n_nsecs   = r_nsecs;
        n_src     = r_src;
        n_dst     = r_dst;
        n_pkts    = r_pkts;
        n_octs    = r_octs;
        n_first   = r_first;
        n_last    = r_last;
        n_sport   = r_sport;
        n_dport   = r_dport;
        n_proto   = r_proto;
        err_fire  = 1'b0;
        err_code  = ST_TRUNCATED;
        o_push    = 1'b0;
        o_entry   = '0;

        if (accept && !i_in.from_originator && i_in.first_byte) begin
            // responder packet start abandons the running packet
            n_dropped = 1'b1;
        end else if (active) begin
            if (i_in.first_byte) begin
                n_hpos    = '0;
                n_off     = '0;
                n_recnum  = '0;
                n_total   = '0;
                n_dropped = 1'b0;
            end
            if (i_in.first_byte && (i_in.packet_length < 16'(HEADER_BYTES))) begin
                err_fire = 1'b1;
                err_code = ST_TRUNCATED;
            end else if (cur_pos < HPOS_W'(HEADER_BYTES)) begin
                // header bytes
                n_hpos = cur_pos + HPOS_W'(1);
                case (cur_pos) inside
                    5'd0: begin
                        n_ver_hi = b;
                    end
                    5'd1: begin
                        if ({r_ver_hi, b} != NF_VERSION) begin
                            err_fire = 1'b1;
                            err_code = ST_BAD_VERSION;
                        end
                    end
                    5'd2: begin
                        n_cnt_hi = b;
                    end
                    5'd3: begin
                        if (count > 16'(MAX_RECORDS)) begin
                            err_fire = 1'b1;
                            err_code = ST_TOO_MANY;
                        end else if (i_in.packet_length < need_len) begin
                            err_fire = 1'b1;
                            err_code = ST_SHORT_DATA;
                        end else begin
                            n_total = count[CNT_W-1:0];
                            if (count == 16'd0) begin
                                n_dropped = 1'b1;
                            end
                        end
                    end
                    [5'd4:5'd7]: begin
                        n_uptime = {r_uptime[23:0], b};
                    end
                    [5'd8:5'd11]: begin
                        n_secs = {r_secs[23:0], b};
                    end
                    [5'd12:5'd15]: begin
                        n_nsecs = {r_nsecs[23:0], b};
                    end
                    default: begin
                    end
                endcase
            end else begin
                // record bytes
                case (cur_off) inside
                    [6'd0:6'd3]:   n_src   = {r_src[23:0], b};
                    [6'd4:6'd7]:   n_dst   = {r_dst[23:0], b};
                    [6'd16:6'd19]: n_pkts  = {r_pkts[23:0], b};
                    [6'd20:6'd23]: n_octs  = {r_octs[23:0], b};
                    [6'd24:6'd27]: n_first = {r_first[23:0], b};
                    [6'd28:6'd31]: n_last  = {r_last[23:0], b};
                    [6'd32:6'd33]: n_sport = {r_sport[7:0], b};
                    [6'd34:6'd35]: n_dport = {r_dport[7:0], b};
                    6'd38:         n_proto = b;
                    default: begin
                    end
                endcase
                if (cur_off == OFF_W'(RECORD_BYTES - 1)) begin
                    n_off    = '0;
                    n_recnum = rec_next[CNT_W-1:0];
                    o_push   = 1'b1;
                    o_entry.status              = ST_RECORD;
                    o_entry.last_record         = (rec_next >= {1'b0, r_total});
                    o_entry.source_address      = r_src;
                    o_entry.destination_address = r_dst;
                    o_entry.source_port         = r_sport;
                    o_entry.destination_port    = r_dport;
                    o_entry.protocol            = r_proto;
                    o_entry.packet_count        = r_pkts;
                    o_entry.octet_count         = r_octs;
                    o_entry.first_ms            = r_first;
                    o_entry.last_ms             = r_last;
                    o_entry.uptime              = r_uptime;
                    o_entry.seconds             = r_secs;
                    o_entry.nanoseconds         = r_nsecs;
                    if (rec_next >= {1'b0, r_total}) begin
                        n_dropped = 1'b1;
                    end
                end else begin
                    n_off = cur_off + OFF_W'(1);
                end
            end

            // error result: status only, packet ignored from here on
            if (err_fire) begin
                n_dropped           = 1'b1;
                o_push              = 1'b1;
                o_entry             = '0;
                o_entry.status      = err_code;
                o_entry.last_record = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hpos    <= '0;
            r_off     <= '0;
            r_recnum  <= '0;
            r_total   <= '0;
            r_dropped <= 1'b1;
            r_ver_hi  <= '0;
            r_cnt_hi  <= '0;
            r_uptime  <= '0;
            r_secs    <= '0;
            r_nsecs   <= '0;
        end else begin
            r_hpos    <= n_hpos;
            r_off     <= n_off;
            r_recnum  <= n_recnum;
            r_total   <= n_total;
            r_dropped <= n_dropped;
            r_ver_hi  <= n_ver_hi;
            r_cnt_hi  <= n_cnt_hi;
            r_uptime  <= n_uptime;
            r_secs    <= n_secs;
            r_nsecs   <= n_nsecs;
        end
    end

    // Record payload
    always_ff @(posedge i_clk) begin
        r_src   <= n_src;
        r_dst   <= n_dst;
        r_pkts  <= n_pkts;
        r_octs  <= n_octs;
        r_first <= n_first;
        r_last  <= n_last;
        r_sport <= n_sport;
        r_dport <= n_dport;
        r_proto <= n_proto;
    end

endmodule

/* sv/nfv5_queue.sv */
// Short FIFO of parsed results between the byte parser and the time pipeline.
module nfv5_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  nfv5_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output nfv5_pkg::t_entry o_entry
);
    import nfv5_pkg::*;

    t_entry            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (QPTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/nfv5_back.sv */
// Time pipeline: converts flow start and end uptimes to unix seconds and drives the result port.
module nfv5_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  nfv5_pkg::t_entry i_entry,
    output logic             o_pop,
    nfv5_out_if.source       o_out
);
    import nfv5_pkg::*;

    // Lane 0 is the flow start, lane 1 the flow end.
    logic en;

    // Stage valids and carried entries
    logic   r_v1, r_v2, r_v3, r_v4, r_ov;
    t_entry r_e1, r_e2, r_e3, r_e4, r_oe;

    // Stage 1: elapsed ms and split of the nanoseconds word
    logic [31:0]     n_d1 [2];
    logic [31:0]     r_d1 [2];
    logic [2:0]      n_nq1;
    logic [NR_W-1:0] n_nr1;
    logic [2:0]      r_nq1, r_nq2, r_nq3;
    logic [NR_W-1:0] r_nr1, r_nr2, r_nr3, r_nr4;

    // Stage 2: reciprocal product
    logic [PROD_W-1:0] r_p2 [2];
    logic [31:0]       r_d2 [2];

    // Stage 3: quotient and remainder by 1000
    logic [DQ_W-1:0] n_dq3 [2];
    logic [9:0]      n_dr3 [2];
    logic [DQ_W-1:0] r_dq3 [2];
    logic [9:0]      r_dr3 [2];

    // Stage 4: remainder in ns and whole-second base
    logic [NR_W-1:0]   r_x4 [2];
    logic [BASE_W-1:0] r_base4 [2];

    // Output stage
    logic [BASE_W-1:0] n_res [2];
    logic [31:0]       n_sec [2];
    logic [31:0]       r_osec [2];

    assign en    = !r_ov || o_out.ready;
    assign o_pop = en && i_valid;

    // Stage 1 logic
    always_comb begin
        n_d1[0] = i_entry.uptime - i_entry.first_ms;
        n_d1[1] = i_entry.uptime - i_entry.last_ms;
        n_nq1   = '0;
        for (int k = 1; k <= NSEC_Q_MAX; k++) begin
            if (i_entry.nanoseconds >= 32'(k) * NS_PER_SEC) begin
                n_nq1 = 3'(k);
            end
        end
        n_nr1 = NR_W'(i_entry.nanoseconds - 32'(n_nq1) * NS_PER_SEC);
    end

    // Stage 3 logic
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_dq3[l] = r_p2[l][PROD_W-1:DIV1000_SHIFT];
            n_dr3[l] = 10'(r_d2[l] - 32'(n_dq3[l]) * 32'(MS_PER_SEC));
        end
    end

    // Output logic: borrow from the sub-second part, then saturate; status-only results give zero
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_res[l] = r_base4[l] - BASE_W'(r_x4[l] > r_nr4);
            if (r_e4.status != ST_RECORD || n_res[l][BASE_W-1]) begin
                n_sec[l] = '0;
            end else if (|n_res[l][BASE_W-2:32]) begin
                n_sec[l] = '1;
            end else begin
                n_sec[l] = n_res[l][31:0];
            end
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_ov <= r_v4;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e1  <= i_entry;
            r_e2  <= r_e1;
            r_e3  <= r_e2;
            r_e4  <= r_e3;
            r_oe  <= r_e4;
            r_nq1 <= n_nq1;
            r_nq2 <= r_nq1;
            r_nq3 <= r_nq2;
            r_nr1 <= n_nr1;
            r_nr2 <= r_nr1;
            r_nr3 <= r_nr2;
            r_nr4 <= r_nr3;
            for (int l = 0; l < 2; l++) begin
                r_d1[l]    <= n_d1[l];
                r_p2[l]    <= PROD_W'(r_d1[l]) * PROD_W'(DIV1000_MAGIC);
                r_d2[l]    <= r_d1[l];
                r_dq3[l]   <= n_dq3[l];
                r_dr3[l]   <= n_dr3[l];
                r_x4[l]    <= NR_W'(r_dr3[l]) * NR_W'(NS_PER_MS);
                r_base4[l] <= BASE_W'(r_e3.seconds) + BASE_W'(r_nq3) - BASE_W'(r_dq3[l]);
                r_osec[l]  <= n_sec[l];
            end
        end
    end

    // Result port
    assign o_out.valid               = r_ov;
    assign o_out.status              = r_oe.status;
    assign o_out.start_seconds       = r_osec[0];
    assign o_out.end_seconds         = r_osec[1];
    assign o_out.source_address      = r_oe.source_address;
    assign o_out.destination_address = r_oe.destination_address;
    assign o_out.source_port         = r_oe.source_port;
    assign o_out.destination_port    = r_oe.destination_port;
    assign o_out.protocol            = r_oe.protocol;
    assign o_out.packet_count        = r_oe.packet_count;
    assign o_out.octet_count         = r_oe.octet_count;
    assign o_out.last_record         = r_oe.last_record;

endmodule

/* sv/netflow_v5_record_parser_top.sv */
// Top level of the NetFlow v5 export packet parser: front parser, result queue, time pipeline.
//
// The block takes one packet byte per beat and sustains one beat every cycle while the queue
// has room. The front parser checks the 24-byte header and captures each 48-byte record as
// it streams past; on a record's last byte, or on a failed check, it pushes one result into
// a four-entry queue in the same cycle. The back end turns the flow start and end uptimes
// into whole unix seconds through a five-register pipeline (a reciprocal multiply does the
// split by 1000); a result leaves the queue through stage registers 1 to 4 and the output
// register before it is offered at the output port. A stalled output stalls only the back
// end; input ready drops only once the queue is full. No memory is cleared after reset: the
// block is ready in the first cycle.
module netflow_v5_record_parser_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nfv5_in_if.sink    i_in,
    nfv5_out_if.source o_out
);
    import nfv5_pkg::*;

    logic   push;
    logic   full;
    logic   pop;
    logic   q_valid;
    t_entry push_entry;
    t_entry q_entry;

    nfv5_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    nfv5_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    nfv5_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_entry (q_entry),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

/* sim/tb.sv */
// Self-checking testbench for the NetFlow v5 export packet parser: byte stream in, flow results out.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nfv5_pkg::*;

    // One packet byte as offered on the input channel
    typedef struct {
        logic [7:0]  data;
        logic        first;
        logic [15:0] len;
        logic        orig;
        bit          drain;     // sender waits for all flows before this beat
    } pkt_byte_t;

    // One parsed flow or header status
    typedef struct packed {
        t_status     status;
        logic [31:0] start_s;
        logic [31:0] end_s;
        logic [31:0] saddr;
        logic [31:0] daddr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
        logic [31:0] pkts;
        logic [31:0] octs;
        logic        last;
    } flow_result_t;

    localparam logic [63:0] NSEC_IN_SEC = 64'd1000000000;
    localparam logic [63:0] NSEC_IN_MS  = 64'd1000000;

    logic i_clk;
    logic i_rst_n;

    nfv5_in_if  bytes_if ();
    nfv5_out_if flows_if ();

    netflow_v5_record_parser_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (bytes_if),
        .o_out   (flows_if)
    );

    // Stimulus and scoreboard storage
    pkt_byte_t    bytes_pending[$];
    flow_result_t flows_due[$];
    logic [7:0]   pkt_buf[$];

    // Parser mirror state
    logic [15:0] pos_in_pkt;
    logic [15:0] flows_declared;
    logic [4:0]  flows_done;
    logic [31:0] hdr_uptime;
    logic [31:0] hdr_secs;
    logic [31:0] hdr_nsecs;
    logic [15:0] version_acc;
    logic [7:0]  rec_bytes[RECORD_BYTES];
    bit          pkt_idle;

    // Handshake bookkeeping
    bit in_acc;
    bit out_acc;
    int tx_gap;
    int rx_gap;
    bit tx_idle_on;
    bit rx_idle_on;
    bit rx_hold;
    bit flood;
    int bytes_taken;
    int results_seen;
    int flow_errors;
    int n_total;
    int cycle_count;
    int cycle_limit = 1000000;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int draw_gap(bit on);
        return on ? int'($urandom_range(0, 11)) : 0;
    endfunction

    function automatic logic [31:0] be32(int at);
        return {rec_bytes[at], rec_bytes[at + 1], rec_bytes[at + 2], rec_bytes[at + 3]};
    endfunction

    // Uptime-relative milliseconds to whole unix seconds, clamped both ways
    function automatic logic [31:0] epoch_secs(logic [31:0] rel_ms);
        logic [31:0] ago_ms;
        logic [63:0] now_ns;
        logic [63:0] back_ns;
        logic [63:0] q;
        ago_ms  = hdr_uptime - rel_ms;
        now_ns  = {32'd0, hdr_secs} * NSEC_IN_SEC + {32'd0, hdr_nsecs};
        back_ns = {32'd0, ago_ms} * NSEC_IN_MS;
        if (back_ns > now_ns)
            return 32'd0;
        q = (now_ns - back_ns) / NSEC_IN_SEC;
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic flow_result_t status_only(t_status s);
        flow_result_t r;
        r = '0;
        r.status = s;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic string flow_str(flow_result_t f);
        return $sformatf("st=%0d start=%h end=%h src=%h dst=%h sp=%h dp=%h pr=%h pk=%h oc=%h l=%0d",
                         f.status, f.start_s, f.end_s, f.saddr, f.daddr, f.sport, f.dport,
                         f.proto, f.pkts, f.octs, f.last);
    endfunction

    // Parser mirror: one accepted beat in, at most one flow result out
    task automatic parse_byte(input pkt_byte_t b, output bit got, output flow_result_t r);
        logic [15:0] pos;
        int off;
        got = 1'b0;
        r = '0;
        if (!b.orig) begin
            if (b.first)
                pkt_idle = 1'b1;
            return;
        end
        if (b.first) begin
            pos_in_pkt = '0;
            flows_done = '0;
            flows_declared = '0;
            pkt_idle = 1'b0;
            if (b.len < HEADER_BYTES) begin
                pkt_idle = 1'b1;
                got = 1'b1;
                r = status_only(ST_TRUNCATED);
                return;
            end
        end else if (pkt_idle) begin
            return;
        end

        pos = pos_in_pkt;
        pos_in_pkt = pos_in_pkt + 16'd1;

        // Header fields
        if (pos < HEADER_BYTES) begin
            if (pos < 2) begin
                version_acc = {version_acc[7:0], b.data};
                if (pos == 1 && version_acc != NF_VERSION) begin
                    pkt_idle = 1'b1;
                    got = 1'b1;
                    r = status_only(ST_BAD_VERSION);
                end
            end else if (pos < 4) begin
                flows_declared = {flows_declared[7:0], b.data};
                if (pos == 3) begin
                    if (flows_declared > MAX_RECORDS) begin
                        pkt_idle = 1'b1;
                        got = 1'b1;
                        r = status_only(ST_TOO_MANY);
                    end else if (int'(b.len) <
                                 HEADER_BYTES + int'(flows_declared) * RECORD_BYTES) begin
                        pkt_idle = 1'b1;
                        got = 1'b1;
                        r = status_only(ST_SHORT_DATA);
                    end else if (flows_declared == 0) begin
                        pkt_idle = 1'b1;
                    end
                end
            end else if (pos < 8) begin
                hdr_uptime = {hdr_uptime[23:0], b.data};
            end else if (pos < 12) begin
                hdr_secs = {hdr_secs[23:0], b.data};
            end else if (pos < 16) begin
                hdr_nsecs = {hdr_nsecs[23:0], b.data};
            end
            return;
        end

        // Record body; anything past the last record is dropped
        off = int'(pos) - HEADER_BYTES - int'(flows_done) * RECORD_BYTES;
        if (off < 0 || off >= RECORD_BYTES) begin
            pkt_idle = 1'b1;
            return;
        end
        rec_bytes[off] = b.data;
        if (off != RECORD_BYTES - 1)
            return;

        flows_done = flows_done + 5'd1;
        got = 1'b1;
        r.status  = ST_RECORD;
        r.start_s = epoch_secs(be32(24));
        r.end_s   = epoch_secs(be32(28));
        r.saddr   = be32(0);
        r.daddr   = be32(4);
        r.sport   = {rec_bytes[32], rec_bytes[33]};
        r.dport   = {rec_bytes[34], rec_bytes[35]};
        r.proto   = rec_bytes[38];
        r.pkts    = be32(16);
        r.octs    = be32(20);
        r.last    = ({11'd0, flows_done} >= flows_declared);
        if (r.last)
            pkt_idle = 1'b1;
    endtask

    // Packet assembly
    task automatic queue_byte(input logic [7:0] d, input logic first, input logic [15:0] len,
                              input logic orig, input bit drain);
        pkt_byte_t b;
        b.data = d;
        b.first = first;
        b.len = len;
        b.orig = orig;
        b.drain = drain;
        bytes_pending.push_back(b);
    endtask

    task automatic put_be(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            pkt_buf.push_back(v[8*i +: 8]);
    endtask

    task automatic put_header(input logic [15:0] ver, input logic [15:0] cnt,
                              input logic [31:0] up, input logic [31:0] secs,
                              input logic [31:0] nsecs);
        put_be(ver, 2);
        put_be(cnt, 2);
        put_be(up, 4);
        put_be(secs, 4);
        put_be(nsecs, 4);
        put_be($urandom, 4);
        put_be($urandom, 4);
    endtask

    // fill: 1 all ones, 2 all zeros, otherwise random
    task automatic put_record(input int fill, input logic [31:0] first_ms,
                              input logic [31:0] last_ms);
        logic [7:0] v;
        for (int i = 0; i < RECORD_BYTES; i++) begin
            v = (fill == 1) ? 8'hFF : (fill == 2) ? 8'h00 : 8'($urandom);
            if (i >= 24 && i < 28)
                v = first_ms[8*(27 - i) +: 8];
            else if (i >= 28 && i < 32)
                v = last_ms[8*(31 - i) +: 8];
            pkt_buf.push_back(v);
        end
    endtask

    task automatic pick_times(input logic [31:0] up, output logic [31:0] f,
                              output logic [31:0] l);
        if ($urandom_range(0, 3) == 0) begin
            f = $urandom;
            l = $urandom;
        end else begin
            f = up - $urandom_range(0, 3600000);
            l = f + $urandom_range(0, 120000);
        end
    endtask

    // Send pkt_buf: cut > 0 stops early, abandon_at >= 0 slips in a responder first beat
    task automatic send_packet(input logic [15:0] decl_len, input int cut, input int abandon_at,
                               input bit noisy, input bit drain);
        int n;
        logic [15:0] len;
        n = (cut > 0 && cut < pkt_buf.size()) ? cut : pkt_buf.size();
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(0, 15) == 0)
                queue_byte(8'($urandom), 1'b0, 16'($urandom), 1'b0, 1'b0);
            if (i == abandon_at)
                queue_byte(8'($urandom), 1'b1, 16'($urandom), 1'b0, 1'b0);
            len = decl_len;
            if (i != 0 && i != 3 && noisy && $urandom_range(0, 3) == 0)
                len = 16'($urandom);
            queue_byte(pkt_buf[i], i == 0, len, 1'b1, drain && i == 0);
        end
        pkt_buf.delete();
    endtask

    // Well-formed packet with n random records, optionally damaged
    task automatic flow_packet(input int n, input int cut, input int abandon_at, input bit noisy,
                               input bit drain);
        logic [31:0] up;
        logic [31:0] nsecs;
        logic [31:0] f;
        logic [31:0] l;
        int need;
        int decl;
        int trail;
        up = $urandom;
        nsecs = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 999999999);
        put_header(NF_VERSION, 16'(n), up, $urandom, nsecs);
        for (int r = 0; r < n; r++) begin
            pick_times(up, f, l);
            put_record(0, f, l);
        end
        need = HEADER_BYTES + n * RECORD_BYTES;
        if ($urandom_range(0, 7) == 0)
            decl = $urandom_range(need, 65535);
        else
            decl = need + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
        trail = (decl > need) ? $urandom_range(0, (decl - need > 6) ? 6 : decl - need) : 0;
        for (int i = 0; i < trail; i++)
            pkt_buf.push_back(8'($urandom));
        send_packet(16'(decl), cut, abandon_at, noisy, drain);
    endtask

    // Input driver: next beat after acceptance and the drawn gap
    always @(negedge i_clk) begin
        pkt_byte_t nxt;
        if (i_rst_n && (!bytes_if.valid || in_acc)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                bytes_if.valid <= 1'b0;
            end else if (bytes_pending.size() != 0 &&
                         !(bytes_pending[0].drain && flows_due.size() != 0)) begin
                nxt = bytes_pending.pop_front();
                bytes_if.data_byte       <= nxt.data;
                bytes_if.first_byte      <= nxt.first;
                bytes_if.packet_length   <= nxt.len;
                bytes_if.from_originator <= nxt.orig;
                bytes_if.valid           <= 1'b1;
                tx_gap = flood ? 0 : draw_gap(tx_idle_on);
                if ($urandom_range(0, 63) == 0)
                    tx_idle_on = !tx_idle_on;
            end else begin
                bytes_if.valid <= 1'b0;
            end
        end
    end

    // Output receiver: random ready gaps, plus the long hold
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_acc) begin
                rx_gap = draw_gap(rx_idle_on);
                if ($urandom_range(0, 63) == 0)
                    rx_idle_on = !rx_idle_on;
            end
            if (rx_hold) begin
                flows_if.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                flows_if.ready <= 1'b0;
            end else begin
                flows_if.ready <= 1'b1;
            end
        end
    end

    // Monitor: check result beats, then predict from the accepted input beat
    always @(posedge i_clk) begin
        flow_result_t act;
        flow_result_t want;
        flow_result_t pred;
        pkt_byte_t b;
        bit got;
        if (i_rst_n) begin
            in_acc  = bytes_if.valid && bytes_if.ready;
            out_acc = flows_if.valid && flows_if.ready;
            if (out_acc) begin
                results_seen++;
                act.status  = t_status'(flows_if.status);
                act.start_s = flows_if.start_seconds;
                act.end_s   = flows_if.end_seconds;
                act.saddr   = flows_if.source_address;
                act.daddr   = flows_if.destination_address;
                act.sport   = flows_if.source_port;
                act.dport   = flows_if.destination_port;
                act.proto   = flows_if.protocol;
                act.pkts    = flows_if.packet_count;
                act.octs    = flows_if.octet_count;
                act.last    = flows_if.last_record;
                if (flows_due.size() == 0) begin
                    flow_errors++;
                    if (flow_errors <= 10)
                        $display("unexpected result beat: %s", flow_str(act));
                end else begin
                    want = flows_due.pop_front();
                    if (act.status !== want.status || act.start_s !== want.start_s ||
                        act.end_s !== want.end_s || act.saddr !== want.saddr ||
                        act.daddr !== want.daddr || act.sport !== want.sport ||
                        act.dport !== want.dport || act.proto !== want.proto ||
                        act.pkts !== want.pkts || act.octs !== want.octs ||
                        act.last !== want.last) begin
                        flow_errors++;
                        if (flow_errors <= 10) begin
                            $display("result mismatch at %0t", $realtime);
                            $display("  expected %s", flow_str(want));
                            $display("  actual   %s", flow_str(act));
                        end
                    end
                end
            end
            if (in_acc) begin
                bytes_taken++;
                b.data  = bytes_if.data_byte;
                b.first = bytes_if.first_byte;
                b.len   = bytes_if.packet_length;
                b.orig  = bytes_if.from_originator;
                b.drain = 1'b0;
                parse_byte(b, got, pred);
                if (got)
                    flows_due.push_back(pred);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > cycle_limit) begin
            $display("FAIL");
            $finish;
        end
    end

    // Long output stall while the sender floods, to fill the block and stall its input
    initial begin
        rx_hold = 1'b0;
        flood = 1'b0;
        wait (results_seen >= 4);
        @(posedge i_clk);
        rx_hold = 1'b1;
        flood = 1'b1;
        repeat (3000) @(posedge i_clk);
        rx_hold = 1'b0;
        flood = 1'b0;
    end

    // Stimulus, reset and end of run
    initial begin
        int kind;
        int n;
        int pkt_idx;
        logic [15:0] ver;
        logic [31:0] up;

        i_rst_n = 1'b0;
        bytes_if.valid = 1'b0;
        bytes_if.data_byte = '0;
        bytes_if.first_byte = 1'b0;
        bytes_if.packet_length = '0;
        bytes_if.from_originator = 1'b0;
        flows_if.ready = 1'b0;
        in_acc = 1'b0;
        out_acc = 1'b0;
        tx_gap = 0;
        rx_gap = 0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        pos_in_pkt = '0;
        flows_declared = '0;
        flows_done = '0;
        hdr_uptime = '0;
        hdr_secs = '0;
        hdr_nsecs = '0;
        version_acc = '0;
        pkt_idle = 1'b1;
        foreach (rec_bytes[i])
            rec_bytes[i] = '0;

        // Directed: header checks
        put_header(NF_VERSION, 16'd1, $urandom, $urandom, 32'd0);
        send_packet(16'd0, 1, -1, 1'b0, 1'b0);          // zero length
        put_header(NF_VERSION, 16'd1, $urandom, $urandom, 32'd0);
        send_packet(16'd23, 2, -1, 1'b0, 1'b0);         // one short of the header
        put_header(16'd4, 16'd1, $urandom, $urandom, 32'd0);
        send_packet(16'd72, 2, -1, 1'b0, 1'b0);         // wrong version
        put_header(16'hFFFF, 16'd1, $urandom, $urandom, 32'd0);
        send_packet(16'd72, 3, -1, 1'b0, 1'b0);
        put_header(NF_VERSION, 16'd31, $urandom, $urandom, 32'd0);
        send_packet(16'hFFFF, 4, -1, 1'b0, 1'b0);       // one record over the maximum
        put_header(NF_VERSION, 16'hFFFF, $urandom, $urandom, 32'd0);
        send_packet(16'hFFFF, 4, -1, 1'b0, 1'b0);
        put_header(NF_VERSION, 16'd1, $urandom, $urandom, 32'd0);
        send_packet(16'd71, 5, -1, 1'b0, 1'b0);         // length one byte short of a record
        // Zero records, then stray beats while idle
        put_header(NF_VERSION, 16'd0, $urandom, $urandom, 32'd0);
        send_packet(16'd24, 0, -1, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b0, 16'hFFFF, 1'b1, 1'b0);
        queue_byte(8'h00, 1'b0, 16'h0000, 1'b0, 1'b0);

        // Time saturation high, all-ones record
        up = $urandom;
        put_header(NF_VERSION, 16'd1, up, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        put_record(1, up, up + 32'd1);
        send_packet(16'd72, 0, -1, 1'b0, 1'b0);
        // Times before the epoch, all-zero record
        up = $urandom;
        put_header(NF_VERSION, 16'd1, up, 32'd0, 32'd0);
        put_record(2, up - 32'd1, up);
        send_packet(16'd72, 0, -1, 1'b0, 1'b0);
        // Maximum record count accepted, first records only
        flow_packet(MAX_RECORDS, HEADER_BYTES + 5 * RECORD_BYTES, -1, 1'b0, 1'b0);
        // Early new packet mid-record, and a responder first beat mid-record
        flow_packet(1, 50, -1, 1'b0, 1'b0);
        flow_packet(1, 0, 40, 1'b0, 1'b0);
        flow_packet(2, 0, -1, 1'b0, 1'b0);

        // Random packets, mostly well-formed
        pkt_idx = 0;
        while (bytes_pending.size() < 1200) begin
            kind = $urandom_range(0, 99);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, MAX_RECORDS)
                                            : $urandom_range(1, 3);
            if (kind < 60) begin
                flow_packet(n, 0, -1, kind < 20, pkt_idx % 8 == 0);
            end else if (kind < 68) begin
                flow_packet(n, $urandom_range(1, HEADER_BYTES + n * RECORD_BYTES - 1), -1,
                            1'b0, 1'b0);
            end else if (kind < 72) begin
                flow_packet(n, 0, $urandom_range(1, HEADER_BYTES + n * RECORD_BYTES - 1),
                            1'b0, 1'b0);
            end else if (kind < 76) begin
                put_header(NF_VERSION, 16'd0, $urandom, $urandom, $urandom);
                for (int i = $urandom_range(0, 4); i > 0; i--)
                    pkt_buf.push_back(8'($urandom));
                send_packet(16'($urandom_range(HEADER_BYTES, 65535)), 0, -1, 1'b1, 1'b0);
            end else if (kind < 82) begin
                put_header(NF_VERSION, 16'(n), $urandom, $urandom, $urandom);
                send_packet(16'($urandom_range(0, HEADER_BYTES - 1)), $urandom_range(1, 5), -1,
                            1'b0, 1'b0);
            end else if (kind < 88) begin
                ver = 16'($urandom);
                if (ver == NF_VERSION)
                    ver ^= 16'h8000;
                put_header(ver, 16'(n), $urandom, $urandom, $urandom);
                send_packet(16'($urandom_range(HEADER_BYTES, 65535)), $urandom_range(2, 8), -1,
                            1'b0, 1'b0);
            end else if (kind < 94) begin
                n = ($urandom_range(0, 1) == 0) ? $urandom_range(MAX_RECORDS + 1, 40)
                                                : $urandom_range(MAX_RECORDS + 1, 65535);
                put_header(NF_VERSION, 16'(n), $urandom, $urandom, $urandom);
                send_packet(16'($urandom), $urandom_range(4, 10), -1, 1'b1, 1'b0);
            end else if (kind < 98) begin
                n = $urandom_range(1, MAX_RECORDS);
                put_header(NF_VERSION, 16'(n), $urandom, $urandom, $urandom);
                send_packet(16'($urandom_range(HEADER_BYTES, HEADER_BYTES + n * RECORD_BYTES - 1)),
                            $urandom_range(4, 10), -1, 1'b1, 1'b0);
            end else begin
                for (int i = $urandom_range(1, 3); i > 0; i--)
                    queue_byte(8'($urandom), 1'b0, 16'($urandom), 1'($urandom), 1'b0);
            end
            pkt_idx++;
        end
        n_total = bytes_pending.size();
        cycle_limit = 80 * n_total + 20000;

        // Reset
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain
        while (bytes_taken < n_total || flows_due.size() != 0)
            @(negedge i_clk);
        repeat (24) @(negedge i_clk);
        if (flow_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
